[design/tmr_pkg.sv]
// ----------------------------------------------------------------------------
// tmr_pkg
// shared types, command and register codes, and the clock-select reload table
// for the divider and reload timer
// ----------------------------------------------------------------------------
`default_nettype none

package tmr_pkg;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned SEL_W   = 2;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CD_W    = 11;   // countdown holds 0..1024 between items
	localparam int unsigned DIFF_W  = 12;   // countdown minus cycles, signed

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// register select codes
	localparam logic [SEL_W-1:0] REG_DIV  = 2'd0;
	localparam logic [SEL_W-1:0] REG_CNT  = 2'd1;
	localparam logic [SEL_W-1:0] REG_MOD  = 2'd2;
	localparam logic [SEL_W-1:0] REG_CTRL = 2'd3;

	// clock-select codes
	localparam logic [SEL_W-1:0] CLK_SEL_1024 = 2'd0;
	localparam logic [SEL_W-1:0] CLK_SEL_16   = 2'd1;
	localparam logic [SEL_W-1:0] CLK_SEL_64   = 2'd2;
	localparam logic [SEL_W-1:0] CLK_SEL_256  = 2'd3;

	localparam int unsigned       ENABLE_BIT = 2;        // control enable (0x04)
	localparam logic [BYTE_W:0]   DIV_LIMIT  = 9'd255;   // divider accumulator wrap
	localparam logic [BYTE_W-1:0] CNT_MAX    = 8'd255;
	localparam logic [CD_W-1:0]   CD_MAX     = 11'd1024;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SEL_W-1:0]  reg_select;
		logic [BYTE_W-1:0] write_data;
		logic [BYTE_W-1:0] tick_cycles;
	} tmr_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              timer_irq;
	} tmr_result_t;

	function automatic logic [CD_W-1:0] reload_value(input logic [SEL_W-1:0] sel);
		logic [CD_W-1:0] v;
		case (sel)
			CLK_SEL_1024: v = 11'd1024;
			CLK_SEL_16:   v = 11'd16;
			CLK_SEL_64:   v = 11'd64;
			CLK_SEL_256:  v = 11'd256;
			default:      v = 11'd1024;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[design/tmr_core.sv]
// ----------------------------------------------------------------------------
// tmr_core
// timer register file and the single-pass update logic for one request
// ----------------------------------------------------------------------------
`default_nettype none

module tmr_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  advance,   // request in the input stage is consumed
	input  tmr_pkg::tmr_item_t   item,
	output tmr_pkg::tmr_result_t result
);

	logic [tmr_pkg::BYTE_W-1:0] acc_q, acc_n;
	logic [tmr_pkg::BYTE_W-1:0] div_q, div_n;
	logic [tmr_pkg::CD_W-1:0]   cd_q, cd_n;
	logic [tmr_pkg::BYTE_W-1:0] cnt_q, cnt_n;
	logic [tmr_pkg::BYTE_W-1:0] mod_q, mod_n;
	logic [tmr_pkg::BYTE_W-1:0] ctrl_q, ctrl_n;

	logic [tmr_pkg::BYTE_W:0]          acc_sum;
	logic signed [tmr_pkg::DIFF_W-1:0] cd_diff;

	assign acc_sum = {1'b0, acc_q} + {1'b0, item.tick_cycles};
	assign cd_diff = $signed({1'b0, cd_q}) - $signed({4'b0000, item.tick_cycles});

	always_comb begin
		acc_n  = acc_q;
		div_n  = div_q;
		cd_n   = cd_q;
		cnt_n  = cnt_q;
		mod_n  = mod_q;
		ctrl_n = ctrl_q;
		result = '0;
		case (item.command)
			tmr_pkg::CMD_TICK: begin
				if (acc_sum >= tmr_pkg::DIV_LIMIT) begin
					acc_n = '0;
					div_n = div_q + 8'd1;
				end else begin
					acc_n = acc_sum[tmr_pkg::BYTE_W-1:0];
				end
				if (ctrl_q[tmr_pkg::ENABLE_BIT]) begin
					if (cd_diff <= 0) begin
						cd_n = tmr_pkg::reload_value(ctrl_q[tmr_pkg::SEL_W-1:0]);
						if (cnt_q == tmr_pkg::CNT_MAX) begin
							cnt_n = mod_q;
							result.timer_irq = 1'b1;
						end else begin
							cnt_n = cnt_q + 8'd1;
						end
					end else begin
						cd_n = cd_diff[tmr_pkg::CD_W-1:0];
					end
				end
			end
			tmr_pkg::CMD_WRITE: begin
				case (item.reg_select)
					tmr_pkg::REG_DIV: div_n = '0;
					tmr_pkg::REG_CNT: cnt_n = item.write_data;
					tmr_pkg::REG_MOD: mod_n = item.write_data;
					tmr_pkg::REG_CTRL: begin
						ctrl_n = item.write_data;
						// new clock select restarts the countdown
						if (item.write_data[tmr_pkg::SEL_W-1:0] != ctrl_q[tmr_pkg::SEL_W-1:0])
							cd_n = tmr_pkg::reload_value(item.write_data[tmr_pkg::SEL_W-1:0]);
					end
					default: ;
				endcase
			end
			tmr_pkg::CMD_READ: begin
				case (item.reg_select)
					tmr_pkg::REG_DIV:  result.read_data = div_q;
					tmr_pkg::REG_CNT:  result.read_data = cnt_q;
					tmr_pkg::REG_MOD:  result.read_data = mod_q;
					tmr_pkg::REG_CTRL: result.read_data = ctrl_q;
					default:           result.read_data = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			div_q  <= '0;
			cd_q   <= '0;
			cnt_q  <= '0;
			mod_q  <= '0;
			ctrl_q <= '0;
		end else if (advance) begin
			acc_q  <= acc_n;
			div_q  <= div_n;
			cd_q   <= cd_n;
			cnt_q  <= cnt_n;
			mod_q  <= mod_n;
			ctrl_q <= ctrl_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, acc_q} < tmr_pkg::DIV_LIMIT)
		else $error("divider accumulator out of range");
	a_cd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cd_q <= tmr_pkg::CD_MAX)
		else $error("countdown out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable({acc_q, div_q, cd_q, cnt_q, mod_q, ctrl_q}))
		else $error("timer state changed without a request");
	a_irq_reload: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.timer_irq |=> cnt_q == $past(mod_q))
		else $error("counter not reloaded from modulo on overflow");
	a_irq_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result.timer_irq |-> item.command == tmr_pkg::CMD_TICK && result.read_data == '0)
		else $error("interrupt outside a tick");
`endif

endmodule

`default_nettype wire

[design/divider_and_reload_timer.sv]
// ----------------------------------------------------------------------------
// divider_and_reload_timer
// divider, counter, modulo and control registers driven by a request stream
// ----------------------------------------------------------------------------
// Each request (a tick, a register write or a register read) gives exactly one
// response, in order. A request is registered on entry, handled by one pass of
// update logic against the timer registers and lands in the response register;
// one request is taken every clock while the response side keeps up. The
// response register decouples the two sides: a new request is taken whenever
// the input stage is empty or the response register is empty or being drained.
// Register reads return the stored byte; ticks and writes return zero data,
// and the response flag marks a counter overflow on a tick.
`default_nettype none

module divider_and_reload_timer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // [7:0] write_data, [15:8] tick_cycles
	input  wire  [3:0]  s_axis_tuser,   // [1:0] command, [3:2] reg_select
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] timer_irq, rest zero
);

	logic                 valid_s1;
	tmr_pkg::tmr_item_t   item_s1;
	logic                 valid_s2;
	tmr_pkg::tmr_result_t result_s2;
	tmr_pkg::tmr_result_t result;
	logic                 out_free;
	logic                 advance;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command     <= s_axis_tuser[1:0];
			item_s1.reg_select  <= s_axis_tuser[3:2];
			item_s1.write_data  <= s_axis_tdata[7:0];
			item_s1.tick_cycles <= s_axis_tdata[15:8];
		end
		if (advance)
			result_s2 <= result;
	end

	tmr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'b0000000, result_s2.timer_irq, result_s2.read_data};

endmodule

`default_nettype wire
